// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/pdf_pkg.sv =====
// Types and constants of the deadband PID controller with filtered derivative.
package pdf_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int SRL_W_MIN = 76;
	localparam int CNT_W = 7;
	localparam int DT_BITS = 32;
	localparam int MS_BITS = 10;
	localparam int ALPHA_BITS = 17;
	localparam int GAIN_BITS = 24;
	localparam int RATE_W = 48;
	localparam int FLT_W = 66;
	localparam int DRV_W = 60;
	localparam int FRAC_BITS = 16;

	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam longint MS_PER_S = 64'sd1000;
	localparam longint RATE_MAX = 64'sd140737488355327;
	localparam longint INC_CAP = 64'sh4000_0000_0000_0000;
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 17'd65536;

	localparam logic [23:0] GAIN_P_RST = 24'd19661;
	localparam logic [23:0] GAIN_I_RST = 24'd0;
	localparam logic [23:0] GAIN_D_RST = 24'd0;
	localparam logic [30:0] DRIVE_LIM_RST = 31'd1310720;
	localparam logic [30:0] INTEG_LIM_RST = 31'd0;
	localparam logic [30:0] DEAD_ZONE_RST = 31'd196608;
	localparam logic [16:0] SMOOTH_RST = 17'd45875;
	localparam logic ANGLE_RST = 1'b0;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DRIVE_LIMIT,
		REG_INTEGRAL_LIMIT,
		REG_DEAD_ZONE,
		REG_SMOOTHING,
		REG_ANGLE_MODE
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_DEAD,
		ST_EDT_MUL,
		ST_EDT_DIV,
		ST_RATE_MUL,
		ST_RATE_DIV,
		ST_FLT_NEW,
		ST_FLT_OLD,
		ST_GAIN_P,
		ST_GAIN_I,
		ST_GAIN_D,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [CNT_W-1:0] count;
	} srl_cmd_t;

endpackage

// ===== src/pdf_serial.sv =====
// Bit-serial unsigned shift-add multiplier and restoring divider.
`include "assert_macros.svh"

module pdf_serial #(
	parameter int SW = pdf_pkg::SRL_W_MIN
) (
	input logic clk,
	input logic arst_n,
	input pdf_pkg::srl_cmd_t cmd,
	input logic [SW-1:0] opa,
	input logic [SW-1:0] opb,
	output logic done,
	output logic [SW-1:0] res,
	output logic [SW-1:0] rmd
);

	logic busy_q;
	logic done_q;
	pdf_pkg::op_t op_q;
	logic [pdf_pkg::CNT_W-1:0] cnt_q;
	logic [SW-1:0] acc_q;
	logic [SW-1:0] mcd_q;
	logic [SW-1:0] mlr_q;
	logic [SW:0] rmd_q;
	logic [SW:0] trial;
	logic fits;

	always_comb begin
		trial = {rmd_q[SW-1:0], acc_q[SW-1]};
		fits = trial >= {1'b0, mcd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= pdf_pkg::OP_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				cnt_q <= cmd.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pdf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcd_q <= (cmd.op == pdf_pkg::OP_MUL) ? opa : opb;
			mlr_q <= opb;
			acc_q <= (cmd.op == pdf_pkg::OP_MUL) ? '0 : opa;
			rmd_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				pdf_pkg::OP_MUL: begin
					if (mlr_q[0])
						acc_q <= acc_q + mcd_q;
					mcd_q <= {mcd_q[SW-2:0], 1'b0};
					mlr_q <= {1'b0, mlr_q[SW-1:1]};
				end
				pdf_pkg::OP_DIV: begin
					rmd_q <= fits ? trial - {1'b0, mcd_q} : trial;
					acc_q <= {acc_q[SW-2:0], fits};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res = acc_q;
	assign rmd = rmd_q[SW-1:0];

	`ASSERT_PROP(a_start_when_free, clk, arst_n, cmd.start |-> !busy_q)
	`ASSERT_NEVER(a_count_live, clk, arst_n, busy_q && cnt_q == '0)
	`ASSERT_PROP(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))

endmodule

// ===== src/pid_deadband_filtered_derivative.sv =====
// Top level of the deadband PID controller with low-pass filtered derivative.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   request  | req_valid, req_stall  | req_type, setpoint, sensed, tick_ms
//   result   | rsp_valid, rsp_stall  | drive, used_error
//   config   | cfg_we                | cfg_index, cfg_data
//
// A reset request does not use the serial unit. An update starts with a
// divide for the angle wrap when it is needed. SW = max(76, VALUE_WIDTH + 32).
// All multiplies and divides run one bit per cycle in one shared serial unit;
// its restoring divides run SW steps.
// Reset clears the controller state and loads the register defaults.
// A new request is taken while a finished result still waits on rsp_stall.
`include "assert_macros.svh"

module pid_deadband_filtered_derivative #(
	parameter int VALUE_WIDTH = pdf_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic req_type,
	input logic signed [31:0] setpoint,
	input logic signed [31:0] sensed,
	input logic [31:0] tick_ms,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic signed [31:0] drive,
	output logic signed [31:0] used_error,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [30:0] cfg_data
);

	localparam int XW = (VALUE_WIDTH > 32 ? VALUE_WIDTH : 32) + 2;
	localparam int SW = (VALUE_WIDTH + 32 > pdf_pkg::SRL_W_MIN) ?
		VALUE_WIDTH + 32 : pdf_pkg::SRL_W_MIN;
	localparam int RW = pdf_pkg::RATE_W;
	localparam int FW = pdf_pkg::FLT_W;
	localparam int DW = pdf_pkg::DRV_W;
	localparam int FB = pdf_pkg::FRAC_BITS;
	localparam logic signed [XW-1:0] VMAX_X =
		{{(XW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
	localparam logic signed [DW-1:0] VMAX_D = DW'(VMAX_X);
	localparam logic signed [DW-1:0] VMIN_D = DW'(VMIN_X);
	localparam logic signed [63:0] VMAX_W = 64'(VMAX_X);
	localparam logic signed [63:0] VMIN_W = 64'(VMIN_X);
	localparam logic [XW-1:0] HALF_U = XW'(pdf_pkg::HALF_TURN);
	localparam logic signed [XW-1:0] HALF_S = XW'(pdf_pkg::HALF_TURN);
	localparam logic signed [XW-1:0] ONE_X = XW'(1);
	localparam logic signed [XW-1:0] E32_MAX = XW'(64'sd2147483647);
	localparam logic signed [XW-1:0] E32_MIN = XW'(-64'sd2147483648);

	function automatic logic signed [XW-1:0] sat_x(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = v;
		if (v > VMAX_X)
			r = VMAX_X;
		if (v < VMIN_X)
			r = VMIN_X;
		return r;
	endfunction

	function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
		return v[XW-1] ? XW'(-v) : XW'(v);
	endfunction

	function automatic logic [RW-1:0] mag_r(input logic signed [RW-1:0] v);
		return v[RW-1] ? RW'(-v) : RW'(v);
	endfunction

	pdf_pkg::state_t state_q, state_n;

	logic [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] dlim_q, ilim_q, dz_q;
	logic [16:0] alpha_q;
	logic angle_q;

	logic signed [XW-1:0] acc_q, lsen_q, lerr_q, ms_q, e_q;
	logic signed [RW-1:0] frate_q, rate_q;
	logic signed [FW-1:0] p_q;
	logic signed [DW-1:0] d_q;
	logic [31:0] ltick_q, dt_q;
	logic issued_q;
	logic rsp_valid_q;
	logic signed [31:0] drive_q, err_q;

	pdf_pkg::srl_cmd_t srl_cmd;
	logic [SW-1:0] srl_a, srl_b, srl_res, srl_rmd;
	logic srl_done;
	logic op_state, need_wrap, out_free, req_take;

	logic signed [XW-1:0] sp_s, ms_s, e_diff, wrap_mag, e_wrap, e_sat, e_dz, x_d;
	logic signed [XW-1:0] ilim_x;
	logic [XW-1:0] em, xm, wrap_a;
	logic [31:0] tdiff, dt_n;
	logic [62:0] inc_mag;
	logic signed [63:0] acc_sum, ilim_w, acc_cl, acc_vw;
	logic [RW-2:0] rate_mag;
	logic signed [RW-1:0] rate_n, frate_n;
	logic [16:0] alpha_c, beta_c;
	logic signed [FW-1:0] pm, p_n, s_sum, s_mag;
	logic [DW-2:0] t_mag;
	logic t_neg;
	logic signed [DW-1:0] t_s, dlim_d, d_cl, d_vw;
	logic signed [XW-1:0] e_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= pdf_pkg::GAIN_P_RST;
			gain_i_q <= pdf_pkg::GAIN_I_RST;
			gain_d_q <= pdf_pkg::GAIN_D_RST;
			dlim_q <= pdf_pkg::DRIVE_LIM_RST;
			ilim_q <= pdf_pkg::INTEG_LIM_RST;
			dz_q <= pdf_pkg::DEAD_ZONE_RST;
			alpha_q <= pdf_pkg::SMOOTH_RST;
			angle_q <= pdf_pkg::ANGLE_RST;
		end else if (cfg_we) begin
			case (pdf_pkg::reg_idx_t'(cfg_index))
				pdf_pkg::REG_GAIN_P: gain_p_q <= cfg_data[23:0];
				pdf_pkg::REG_GAIN_I: gain_i_q <= cfg_data[23:0];
				pdf_pkg::REG_GAIN_D: gain_d_q <= cfg_data[23:0];
				pdf_pkg::REG_DRIVE_LIMIT: dlim_q <= cfg_data;
				pdf_pkg::REG_INTEGRAL_LIMIT: ilim_q <= cfg_data;
				pdf_pkg::REG_DEAD_ZONE: dz_q <= cfg_data;
				pdf_pkg::REG_SMOOTHING: alpha_q <= cfg_data[16:0];
				pdf_pkg::REG_ANGLE_MODE: angle_q <= cfg_data[0];
				default: angle_q <= angle_q;
			endcase
		end
	end

	always_comb begin
		sp_s = sat_x(XW'(setpoint));
		ms_s = sat_x(XW'(sensed));
		e_diff = sp_s - ms_s;
		tdiff = tick_ms - ltick_q;
		dt_n = (tdiff == 32'd0) ? 32'd1 : tdiff;

		em = mag_x(e_q);
		need_wrap = angle_q && (em > HALF_U);
		wrap_a = em - HALF_U - XW'(1);
		wrap_mag = signed'(XW'(srl_rmd)) - HALF_S + ONE_X;
		e_wrap = e_q[XW-1] ? -wrap_mag : wrap_mag;
		e_sat = sat_x(e_q);
		e_dz = (mag_x(e_sat) < XW'(dz_q)) ? '0 : e_sat;

		inc_mag = (srl_res > SW'(pdf_pkg::INC_CAP)) ? 63'(pdf_pkg::INC_CAP) : srl_res[62:0];
		acc_sum = 64'(acc_q) + (e_q[XW-1] ? -signed'({1'b0, inc_mag}) :
			signed'({1'b0, inc_mag}));
		ilim_w = signed'(64'(ilim_q));
		ilim_x = signed'(XW'(ilim_q));
		acc_cl = acc_sum;
		if (acc_sum > ilim_w)
			acc_cl = ilim_w;
		if (acc_sum < -ilim_w)
			acc_cl = -ilim_w;
		acc_vw = acc_cl;
		if (acc_cl > VMAX_W)
			acc_vw = VMAX_W;
		if (acc_cl < VMIN_W)
			acc_vw = VMIN_W;

		x_d = angle_q ? e_q - lerr_q : ms_q - lsen_q;
		xm = mag_x(x_d);
		rate_mag = (srl_res > SW'(pdf_pkg::RATE_MAX)) ?
			(RW-1)'(pdf_pkg::RATE_MAX) : srl_res[RW-2:0];
		rate_n = x_d[XW-1] ? -signed'({1'b0, rate_mag}) : signed'({1'b0, rate_mag});

		alpha_c = (alpha_q > pdf_pkg::ALPHA_ONE) ? pdf_pkg::ALPHA_ONE : alpha_q;
		beta_c = pdf_pkg::ALPHA_ONE - alpha_c;
		pm = {1'b0, srl_res[FW-2:0]};
		p_n = rate_q[RW-1] ? -pm : pm;
		s_sum = p_q + (frate_q[RW-1] ? -pm : pm);
		s_mag = s_sum[FW-1] ? -s_sum : s_sum;
		frate_n = s_sum[FW-1] ? -signed'(s_mag[FB +: RW]) : signed'(s_mag[FB +: RW]);

		t_mag = srl_res[FB +: DW-1];
		case (state_q)
			pdf_pkg::ST_GAIN_P: t_neg = e_q[XW-1];
			pdf_pkg::ST_GAIN_I: t_neg = acc_q[XW-1];
			pdf_pkg::ST_GAIN_D: t_neg = frate_q[RW-1] ^ !angle_q;
			default: t_neg = 1'b0;
		endcase
		t_s = t_neg ? -signed'({1'b0, t_mag}) : signed'({1'b0, t_mag});

		dlim_d = signed'(DW'(dlim_q));
		d_cl = d_q;
		if (d_q > dlim_d)
			d_cl = dlim_d;
		if (d_q < -dlim_d)
			d_cl = -dlim_d;
		d_vw = d_cl;
		if (d_cl > VMAX_D)
			d_vw = VMAX_D;
		if (d_cl < VMIN_D)
			d_vw = VMIN_D;
		e_out = e_q;
		if (e_q > E32_MAX)
			e_out = E32_MAX;
		if (e_q < E32_MIN)
			e_out = E32_MIN;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			pdf_pkg::ST_IDLE: begin
				if (req_valid)
					state_n = req_type ? pdf_pkg::ST_DONE : pdf_pkg::ST_WRAP;
			end
			pdf_pkg::ST_WRAP: begin
				if (!need_wrap || srl_done)
					state_n = pdf_pkg::ST_DEAD;
			end
			pdf_pkg::ST_DEAD: state_n = pdf_pkg::ST_EDT_MUL;
			pdf_pkg::ST_EDT_MUL: if (srl_done) state_n = pdf_pkg::ST_EDT_DIV;
			pdf_pkg::ST_EDT_DIV: if (srl_done) state_n = pdf_pkg::ST_RATE_MUL;
			pdf_pkg::ST_RATE_MUL: if (srl_done) state_n = pdf_pkg::ST_RATE_DIV;
			pdf_pkg::ST_RATE_DIV: if (srl_done) state_n = pdf_pkg::ST_FLT_NEW;
			pdf_pkg::ST_FLT_NEW: if (srl_done) state_n = pdf_pkg::ST_FLT_OLD;
			pdf_pkg::ST_FLT_OLD: if (srl_done) state_n = pdf_pkg::ST_GAIN_P;
			pdf_pkg::ST_GAIN_P: if (srl_done) state_n = pdf_pkg::ST_GAIN_I;
			pdf_pkg::ST_GAIN_I: if (srl_done) state_n = pdf_pkg::ST_GAIN_D;
			pdf_pkg::ST_GAIN_D: if (srl_done) state_n = pdf_pkg::ST_DONE;
			pdf_pkg::ST_DONE: if (out_free) state_n = pdf_pkg::ST_IDLE;
			default: state_n = pdf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = state_q != pdf_pkg::ST_IDLE;
		req_take = req_valid && !req_stall;
		out_free = !rsp_valid_q || !rsp_stall;
		op_state = state_q inside {pdf_pkg::ST_WRAP, pdf_pkg::ST_EDT_MUL,
			pdf_pkg::ST_EDT_DIV, pdf_pkg::ST_RATE_MUL, pdf_pkg::ST_RATE_DIV,
			pdf_pkg::ST_FLT_NEW, pdf_pkg::ST_FLT_OLD, pdf_pkg::ST_GAIN_P,
			pdf_pkg::ST_GAIN_I, pdf_pkg::ST_GAIN_D};
		srl_cmd.start = op_state && !issued_q &&
			!(state_q == pdf_pkg::ST_WRAP && !need_wrap);
		srl_cmd.op = pdf_pkg::OP_MUL;
		srl_cmd.count = pdf_pkg::CNT_W'(SW);
		srl_a = '0;
		srl_b = '0;
		case (state_q)
			pdf_pkg::ST_WRAP: begin
				srl_cmd.op = pdf_pkg::OP_DIV;
				srl_a = SW'(wrap_a);
				srl_b = SW'(pdf_pkg::FULL_TURN);
			end
			pdf_pkg::ST_EDT_MUL: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::DT_BITS);
				srl_a = SW'(em);
				srl_b = SW'(dt_q);
			end
			pdf_pkg::ST_EDT_DIV: begin
				srl_cmd.op = pdf_pkg::OP_DIV;
				srl_a = srl_res;
				srl_b = SW'(pdf_pkg::MS_PER_S);
			end
			pdf_pkg::ST_RATE_MUL: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::MS_BITS);
				srl_a = SW'(xm);
				srl_b = SW'(pdf_pkg::MS_PER_S);
			end
			pdf_pkg::ST_RATE_DIV: begin
				srl_cmd.op = pdf_pkg::OP_DIV;
				srl_a = srl_res;
				srl_b = SW'(dt_q);
			end
			pdf_pkg::ST_FLT_NEW: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::ALPHA_BITS);
				srl_a = SW'(mag_r(rate_q));
				srl_b = SW'(alpha_c);
			end
			pdf_pkg::ST_FLT_OLD: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::ALPHA_BITS);
				srl_a = SW'(mag_r(frate_q));
				srl_b = SW'(beta_c);
			end
			pdf_pkg::ST_GAIN_P: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::GAIN_BITS);
				srl_a = SW'(em);
				srl_b = SW'(gain_p_q);
			end
			pdf_pkg::ST_GAIN_I: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::GAIN_BITS);
				srl_a = SW'(mag_x(acc_q));
				srl_b = SW'(gain_i_q);
			end
			pdf_pkg::ST_GAIN_D: begin
				srl_cmd.count = pdf_pkg::CNT_W'(pdf_pkg::GAIN_BITS);
				srl_a = SW'(mag_r(frate_q));
				srl_b = SW'(gain_d_q);
			end
			default: begin
				srl_a = '0;
			end
		endcase
	end

	pdf_serial #(
		.SW(SW)
	) u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(srl_cmd),
		.opa(srl_a),
		.opb(srl_b),
		.done(srl_done),
		.res(srl_res),
		.rmd(srl_rmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdf_pkg::ST_IDLE;
			issued_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			acc_q <= '0;
			lsen_q <= '0;
			lerr_q <= '0;
			frate_q <= '0;
			ltick_q <= '0;
		end else begin
			state_q <= state_n;
			if (srl_done)
				issued_q <= 1'b0;
			else if (srl_cmd.start)
				issued_q <= 1'b1;
			if (req_take) begin
				ltick_q <= tick_ms;
				if (req_type) begin
					acc_q <= '0;
					lsen_q <= '0;
					lerr_q <= '0;
					frate_q <= '0;
				end
			end
			if (srl_done && state_q == pdf_pkg::ST_EDT_DIV)
				acc_q <= XW'(acc_vw);
			if (srl_done && state_q == pdf_pkg::ST_FLT_OLD)
				frate_q <= frate_n;
			if (srl_done && state_q == pdf_pkg::ST_GAIN_D) begin
				lsen_q <= ms_q;
				lerr_q <= e_q;
			end
			if (state_q == pdf_pkg::ST_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			dt_q <= dt_n;
			ms_q <= ms_s;
			e_q <= req_type ? '0 : e_diff;
			d_q <= '0;
		end
		if (srl_done && state_q == pdf_pkg::ST_WRAP)
			e_q <= e_wrap;
		if (state_q == pdf_pkg::ST_DEAD)
			e_q <= e_dz;
		if (srl_done && state_q == pdf_pkg::ST_RATE_DIV)
			rate_q <= rate_n;
		if (srl_done && state_q == pdf_pkg::ST_FLT_NEW)
			p_q <= p_n;
		if (srl_done && state_q == pdf_pkg::ST_GAIN_P)
			d_q <= t_s;
		if (srl_done && (state_q == pdf_pkg::ST_GAIN_I || state_q == pdf_pkg::ST_GAIN_D))
			d_q <= d_q + t_s;
		if (state_q == pdf_pkg::ST_DONE && out_free) begin
			drive_q <= d_vw[31:0];
			err_q <= e_out[31:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign drive = drive_q;
	assign used_error = err_q;

	`ASSERT_PROP(a_done_issued, clk, arst_n, srl_done |-> issued_q)
	`ASSERT_PROP(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == pdf_pkg::ST_DONE))
	`ASSERT_PROP(a_acc_in_limit, clk, arst_n, (state_q == pdf_pkg::ST_RATE_MUL) |-> (acc_q <= ilim_x && acc_q >= -ilim_x))
	`ASSERT_PROP(a_wrap_bound, clk, arst_n, (state_q == pdf_pkg::ST_DEAD && angle_q) |-> (em <= HALF_U))

endmodule

// ===== sim/pid_deadband_filtered_derivative_tb.sv =====
// Testbench of the deadband PID controller: directed and random requests checked against a built-in predictor.
`timescale 1ns / 1ps

module pid_deadband_filtered_derivative_tb;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint LIMIT_CYCLES = 64'd3000000;

	typedef struct {
		logic signed [31:0] drive;
		logic signed [31:0] used_error;
	} pid_out_t;

	class pid_scoreboard;
		logic [23:0] kp, ki, kd;
		longint out_lim, int_lim, dz;
		logic [16:0] alpha;
		bit yaw;
		longint integ, prev_meas, prev_err, rate_f;
		logic [31:0] prev_tick;
		pid_out_t pending[$];
		int errors;

		function void defaults();
			kp = pdf_pkg::GAIN_P_RST; ki = pdf_pkg::GAIN_I_RST; kd = pdf_pkg::GAIN_D_RST;
			out_lim = pdf_pkg::DRIVE_LIM_RST; int_lim = pdf_pkg::INTEG_LIM_RST;
			dz = pdf_pkg::DEAD_ZONE_RST;
			alpha = pdf_pkg::SMOOTH_RST; yaw = pdf_pkg::ANGLE_RST;
			integ = 0; prev_meas = 0; prev_err = 0; rate_f = 0; prev_tick = 0;
			errors = 0;
		endfunction

		function void write_reg(pdf_pkg::reg_idx_t idx, logic [30:0] d);
			case (idx)
				pdf_pkg::REG_GAIN_P: kp = d[23:0];
				pdf_pkg::REG_GAIN_I: ki = d[23:0];
				pdf_pkg::REG_GAIN_D: kd = d[23:0];
				pdf_pkg::REG_DRIVE_LIMIT: out_lim = d;
				pdf_pkg::REG_INTEGRAL_LIMIT: int_lim = d;
				pdf_pkg::REG_DEAD_ZONE: dz = d;
				pdf_pkg::REG_SMOOTHING: alpha = d[16:0];
				pdf_pkg::REG_ANGLE_MODE: yaw = d[0];
				default: yaw = yaw;
			endcase
		endfunction

		function longint clamp(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function longint scale_gain(logic [23:0] g, longint v);
			longint unsigned m, p;
			m = (v < 0) ? -v : v;
			p = longint'(g) * (m >> 16) + ((longint'(g) * (m & 64'hFFFF)) >> 16);
			return (v < 0) ? -longint'(p) : longint'(p);
		endfunction

		function longint err_times_dt(longint e, logic [31:0] dt);
			longint unsigned m, q, r, p, cap;
			cap = 64'h4000_0000_0000_0000;
			m = (e < 0) ? -e : e;
			q = m / 1000; r = m % 1000;
			if (q != 0 && longint'(dt) > cap / q) p = cap;
			else begin
				p = q * dt + (r * dt) / 1000;
				if (p > cap) p = cap;
			end
			return (e < 0) ? -longint'(p) : longint'(p);
		endfunction

		function void note_request(bit is_reset, logic signed [31:0] sp,
				logic signed [31:0] ms, logic [31:0] tick);
			pid_out_t r;
			logic [31:0] dt;
			longint e, x, rate, a, drv;
			logic signed [128:0] fsum;
			if (is_reset) begin
				integ = 0; prev_meas = 0; prev_err = 0; rate_f = 0; prev_tick = tick;
				r.drive = 0; r.used_error = 0;
				pending.push_back(r);
				return;
			end
			dt = tick - prev_tick;
			prev_tick = tick;
			if (dt == 0) dt = 1;
			e = longint'(sp) - longint'(ms);
			if (yaw) begin
				if (e > pdf_pkg::HALF_TURN)
					e -= ((e - pdf_pkg::HALF_TURN + pdf_pkg::FULL_TURN - 1) /
						pdf_pkg::FULL_TURN) * pdf_pkg::FULL_TURN;
				else if (e < -pdf_pkg::HALF_TURN)
					e += ((-pdf_pkg::HALF_TURN - e + pdf_pkg::FULL_TURN - 1) /
						pdf_pkg::FULL_TURN) * pdf_pkg::FULL_TURN;
			end
			if (e > VMAX) e = VMAX;
			if (e < VMIN) e = VMIN;
			if (((e < 0) ? -e : e) < dz) e = 0;
			integ = clamp(integ + err_times_dt(e, dt), int_lim);
			x = yaw ? (e - prev_err) : (longint'(ms) - prev_meas);
			rate = clamp((x * 1000) / longint'(dt), pdf_pkg::RATE_MAX);
			a = (alpha > pdf_pkg::ALPHA_ONE) ? 65536 : longint'(alpha);
			fsum = 129'(a) * 129'(rate) + 129'(65536 - a) * 129'(rate_f);
			rate_f = longint'(fsum / 65536);
			drv = scale_gain(kp, e) + scale_gain(ki, integ);
			if (yaw) drv += scale_gain(kd, rate_f);
			else drv -= scale_gain(kd, rate_f);
			drv = clamp(drv, out_lim);
			prev_meas = ms;
			prev_err = e;
			r.drive = drv[31:0];
			r.used_error = e[31:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] d, logic signed [31:0] u);
			pid_out_t x;
			if (pending.size() == 0) begin
				$error("unexpected result drive=%0d used_error=%0d", d, u);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (d !== x.drive) begin
				$error("drive expected %0d actual %0d", x.drive, d);
				errors++;
			end
			if (u !== x.used_error) begin
				$error("used_error expected %0d actual %0d", x.used_error, u);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	logic req_type = 0;
	logic signed [31:0] setpoint = 0;
	logic signed [31:0] sensed = 0;
	logic [31:0] tick_ms = 0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic signed [31:0] drive;
	logic signed [31:0] used_error;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [30:0] cfg_data = 0;

	pid_scoreboard sb = new();
	bit quiet = 0;
	bit stim_done = 0;
	longint cycles = 0;
	logic [31:0] clock_ms = 0;

	pid_deadband_filtered_derivative dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && rsp_valid && !rsp_stall)
		sb.check_result(drive, used_error);

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 6);
				rsp_stall <= 1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 0;
		end
	end

	task automatic send(bit rt, logic signed [31:0] sp, logic signed [31:0] ms,
			logic [31:0] tk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1; req_type <= rt; setpoint <= sp; sensed <= ms; tick_ms <= tk;
		do @(posedge clk); while (req_stall);
		sb.note_request(rt, sp, ms, tk);
	endtask

	task automatic drain();
		req_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_reg(pdf_pkg::reg_idx_t idx, logic [30:0] d);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic random_regs(bit extreme);
		set_reg(pdf_pkg::REG_GAIN_P, extreme ? 31'hFFFFFF : 31'($urandom_range(0, 200000)));
		set_reg(pdf_pkg::REG_GAIN_I, extreme ? 31'hFFFFFF : 31'($urandom_range(0, 100000)));
		set_reg(pdf_pkg::REG_GAIN_D, extreme ? 31'hFFFFFF : 31'($urandom_range(0, 100000)));
		set_reg(pdf_pkg::REG_DRIVE_LIMIT,
			extreme ? 31'h7FFFFFFF : 31'($urandom_range(0, 31'h7FFFFFFF)));
		set_reg(pdf_pkg::REG_INTEGRAL_LIMIT,
			extreme ? 31'h7FFFFFFF : 31'($urandom_range(0, 50000000)));
		set_reg(pdf_pkg::REG_DEAD_ZONE, extreme ? 31'd0 : 31'($urandom_range(0, 500000)));
		set_reg(pdf_pkg::REG_SMOOTHING, extreme ? 31'h1FFFF : 31'($urandom_range(0, 65536)));
		set_reg(pdf_pkg::REG_ANGLE_MODE, 31'($urandom_range(0, 1)));
	endtask

	task automatic random_request(int kind);
		logic signed [31:0] sp, ms;
		clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 20));
		if (kind == 0) begin
			sp = $urandom(); ms = $urandom();
		end else begin
			sp = $signed($urandom_range(0, 50000000)) - 25000000;
			ms = $signed($urandom_range(0, 50000000)) - 25000000;
		end
		send($urandom_range(0, 19) == 0, sp, ms, clock_ms);
	endtask

	initial begin
		sb.defaults();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, reset request, zero dt, wrap boundary
		send(0, 32'sh7FFFFFFF, 32'sh80000000, 0);
		send(0, 32'sh80000000, 32'sh7FFFFFFF, 0);
		send(1, 0, 0, 32'hFFFFFFF0);
		send(0, 1000, 0, 32'h00000005);
		drain();
		random_regs(1);
		drain();
		random_regs(1);
		set_reg(pdf_pkg::REG_ANGLE_MODE, 31'd1);
		send(0, 32'sd11796480, 0, 10);
		send(0, -32'sd11796480, 0, 11);
		send(0, 32'sd11796481, 0, 11);
		send(0, 32'sh7FFFFFFF, 32'sh80000000, 12);
		send(0, 32'sh80000000, 32'sh7FFFFFFF, 32'hFFFFFFFF);
		send(1, 0, 0, 32'hFFFFFFFF);
		send(0, -32'sd40000000, 32'sd50000000, 3);
		drain();
		set_reg(pdf_pkg::REG_ANGLE_MODE, 31'd0);
		set_reg(pdf_pkg::REG_DEAD_ZONE, 31'h7FFFFFFF);
		set_reg(pdf_pkg::REG_SMOOTHING, 31'd0);
		send(0, 32'sh7FFFFFFF, 32'sh80000000, 20);
		send(0, 12345, -9876, 21);
		drain();
		for (int ph = 0; ph < 9; ph++) begin
			random_regs(ph == 4);
			if (ph == 8) quiet = 1;
			for (int i = 0; i < 100; i++) random_request($urandom_range(0, 3) == 0 ? 0 : 1);
			drain();
		end
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/pdf_pkg.sv
src/pdf_serial.sv
src/pid_deadband_filtered_derivative.sv
sim/pid_deadband_filtered_derivative_tb.sv
